[src/fdl_pkg.sv]
// Shared types, constants and codes for the fractional delay line.
package fdl_pkg;

  localparam int DATA_W        = 32;
  localparam int FRAC_W        = 16;
  localparam int STEP_W        = 11;
  localparam int TAP_W         = 10;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_W         = DATA_W;
  localparam int MAX_DELAY_DEF = 1024;
  localparam int WGT_W         = FRAC_W + 2;           // signed weight, holds 1.0
  localparam int PROD_W        = DATA_W + WGT_W;

  localparam logic [FRAC_W:0]   FRAC_ONE  = 17'h10000;
  localparam logic [FRAC_W-1:0] FRAC_MASK = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_FILL = 2'd1,
    OP_READ = 2'd2,
    OP_NOP  = 2'd3
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP = 2'd0,
    REG_FRAC = 2'd1,
    REG_INIT = 2'd2
  } cfg_reg_t;

  // how the result of an item is formed at the output stage
  typedef enum logic [1:0] {
    MODE_ZERO   = 2'd0,
    MODE_TAP    = 2'd1,
    MODE_INTERP = 2'd2,
    MODE_ERR    = 2'd3
  } res_mode_t;

  typedef struct packed {
    opcode_t                    opcode;
    logic signed [DATA_W-1:0]   sample_in;
    logic        [TAP_W-1:0]    tap_index;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]   sample_out;
    logic                       index_error;
  } out_item_t;

  typedef struct packed {
    logic shift;
    logic fill;
  } cell_ctl_t;

  typedef struct packed {
    logic sel1;
    logic sel2;
    logic mul;
    logic add;
  } pipe_ld_t;

endpackage

[src/fractional_delay_line_core.sv]
// Top level of the fractional delay line: cell chain, tap selectors and result pipeline.
//
// Usage:
//   Input items (in_valid/in_stall/in_data) carry an opcode: push a sample
//   and get the delayed value, fill the line with init_value, read one tap
//   (0 = newest) with an out-of-range flag, or do nothing. Every item gives
//   exactly one result item on out_valid/out_stall/out_data, in order.
//   Configuration (cfg_we/cfg_addr/cfg_wdata) sets step_delay, frac_weight
//   and init_value; write it only while no item is in flight.
//   Storage is a row of MAX_DELAY cells; a push with nonzero step_delay
//   shifts every cell one place toward the old end, a fill loads all cells
//   in the same cycle. Throughput: one item per cycle while the result
//   side does not stall. The chain is sampled by a two-level registered
//   selector as the item leaves stage 0, and stage 0 takes no new item
//   before then, so a following push never disturbs an earlier item's read.
//   Reset (rst_n low, synchronous) clears the cells, the configuration
//   registers and the pipeline valid bits; no clearing pass is needed.
//   A stall on the result side holds the output item; the five pipeline
//   stages keep filling behind it and in_stall rises only once all of them
//   are occupied.
module fractional_delay_line_core #(
  parameter int MAX_DELAY = fdl_pkg::MAX_DELAY_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  fdl_pkg::in_item_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output fdl_pkg::out_item_t                 out_data,
  input  logic                               cfg_we,
  input  logic [fdl_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [fdl_pkg::CFG_W-1:0]          cfg_wdata
);

  localparam int AW    = $clog2(MAX_DELAY);
  localparam int LEN_W = $clog2(MAX_DELAY + 1);
  localparam int DW    = fdl_pkg::DATA_W;
  localparam int NST   = 5;                 // stages ahead of the output register

  // ---------------------------------------------------------------- config
  logic [fdl_pkg::STEP_W-1:0]  step_r;
  logic [fdl_pkg::FRAC_W-1:0]  frac_r;
  logic [DW-1:0]               init_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      frac_r <= '0;
      init_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        fdl_pkg::REG_STEP: step_r <= cfg_wdata[fdl_pkg::STEP_W-1:0];
        fdl_pkg::REG_FRAC: frac_r <= cfg_wdata[fdl_pkg::FRAC_W-1:0];
        fdl_pkg::REG_INIT: init_r <= cfg_wdata[DW-1:0];
        default: ;
      endcase
    end
  end

  // effective length saturates at the chain size
  logic [LEN_W-1:0] len;
  logic [LEN_W-1:0] len_m1;
  logic [LEN_W-1:0] len_m2;

  assign len    = (32'(step_r) > MAX_DELAY) ? LEN_W'(MAX_DELAY) : LEN_W'(step_r);
  assign len_m1 = len - LEN_W'(1);
  assign len_m2 = len - LEN_W'(2);

  // ---------------------------------------------------------------- handshake
  logic [NST-1:0]              v_r;
  logic [NST:0]                rdy;
  logic                        out_valid_r;
  logic                        accept;

  always_comb begin
    rdy[NST] = !out_valid_r || !out_stall;
    for (int k = NST - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign in_stall = !rdy[0];
  assign accept   = in_valid && rdy[0];

  // ---------------------------------------------------------------- decode
  fdl_pkg::res_mode_t  mode_nxt;
  logic [AW-1:0]       addr_a_nxt;
  logic                tap_bad;

  assign tap_bad = 32'(in_data.tap_index) >= 32'(len);

  always_comb begin
    case (in_data.opcode)
      fdl_pkg::OP_PUSH: begin
        if (len == '0) begin
          mode_nxt = fdl_pkg::MODE_ZERO;
        end else if (frac_r != '0 && len >= LEN_W'(2)) begin
          mode_nxt = fdl_pkg::MODE_INTERP;
        end else begin
          mode_nxt = fdl_pkg::MODE_TAP;
        end
      end
      fdl_pkg::OP_READ: begin
        mode_nxt = tap_bad ? fdl_pkg::MODE_ERR : fdl_pkg::MODE_TAP;
      end
      default: mode_nxt = fdl_pkg::MODE_ZERO;
    endcase
  end

  // port A: oldest entry for a push, the asked tap for a read
  assign addr_a_nxt = (in_data.opcode == fdl_pkg::OP_READ) ? AW'(in_data.tap_index)
                                                           : AW'(len_m1);

  // ---------------------------------------------------------------- cell chain
  fdl_pkg::cell_ctl_t  cell_ctl;
  logic [DW-1:0]       cell_q [MAX_DELAY];

  assign cell_ctl.shift = accept && in_data.opcode == fdl_pkg::OP_PUSH && len != '0;
  assign cell_ctl.fill  = accept && in_data.opcode == fdl_pkg::OP_FILL;

  for (genvar k = 0; k < MAX_DELAY; k++) begin : g_cell
    logic [DW-1:0] d_in;
    if (k == 0) begin : g_head
      assign d_in = in_data.sample_in;
    end else begin : g_body
      assign d_in = cell_q[k-1];
    end

    fdl_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (cell_ctl),
      .d_prev   (d_in),
      .init_val (init_r),
      .q        (cell_q[k])
    );
  end

  // ---------------------------------------------------------------- pipeline
  // stage 0: chain updated, addresses held
  // stage 1: first selector level, stage 2: a and b
  // stage 3: products, stage 4: sum, then the output register
  fdl_pkg::res_mode_t  mode_r [NST];
  logic [AW-1:0]       addr_a_r;
  logic [AW-1:0]       addr_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      mode_r[0] <= mode_nxt;
      addr_a_r  <= addr_a_nxt;
      addr_b_r  <= AW'(len_m2);
    end
    for (int k = 1; k < NST; k++) begin
      if (rdy[k]) begin
        mode_r[k] <= mode_r[k-1];
      end
    end
  end

  fdl_pkg::pipe_ld_t ld;

  assign ld.sel1 = rdy[1];
  assign ld.sel2 = rdy[2];
  assign ld.mul  = rdy[3];
  assign ld.add  = rdy[4];

  logic [DW-1:0] val_a;
  logic [DW-1:0] val_b;

  fdl_tap_sel #(
    .MAX_DELAY (MAX_DELAY),
    .AW        (AW)
  ) u_sel_a (
    .clk    (clk),
    .ld     (ld),
    .cell_q (cell_q),
    .addr   (addr_a_r),
    .val    (val_a)
  );

  fdl_tap_sel #(
    .MAX_DELAY (MAX_DELAY),
    .AW        (AW)
  ) u_sel_b (
    .clk    (clk),
    .ld     (ld),
    .cell_q (cell_q),
    .addr   (addr_b_r),
    .val    (val_b)
  );

  logic signed [DW-1:0] interp_val;
  logic signed [DW-1:0] pass_val;

  fdl_interp u_interp (
    .clk        (clk),
    .ld         (ld),
    .a          ($signed(val_a)),
    .b          ($signed(val_b)),
    .frac       (frac_r),
    .interp_val (interp_val),
    .pass_val   (pass_val)
  );

  // ---------------------------------------------------------------- output
  fdl_pkg::out_item_t out_nxt;
  fdl_pkg::out_item_t out_r;

  always_comb begin
    out_nxt = '0;
    case (mode_r[NST-1])
      fdl_pkg::MODE_INTERP: out_nxt.sample_out  = interp_val;
      fdl_pkg::MODE_TAP:    out_nxt.sample_out  = pass_val;
      fdl_pkg::MODE_ERR:    out_nxt.index_error = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy[NST]) begin
      out_valid_r <= v_r[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NST]) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[src/fdl_cell.sv]
// One storage cell of the delay chain: shifts from its neighbor or loads the fill value.
module fdl_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  fdl_pkg::cell_ctl_t           ctl,
  input  logic [fdl_pkg::DATA_W-1:0]   d_prev,
  input  logic [fdl_pkg::DATA_W-1:0]   init_val,
  output logic [fdl_pkg::DATA_W-1:0]   q
);

  logic [fdl_pkg::DATA_W-1:0] q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else if (ctl.fill) begin
      q_r <= init_val;
    end else if (ctl.shift) begin
      q_r <= d_prev;
    end
  end

  assign q = q_r;

endmodule

[src/fdl_tap_sel.sv]
// Two-level registered selector that picks one cell of the chain by address.
module fdl_tap_sel #(
  parameter int MAX_DELAY = fdl_pkg::MAX_DELAY_DEF,
  parameter int AW        = $clog2(MAX_DELAY)
) (
  input  logic                         clk,
  input  fdl_pkg::pipe_ld_t            ld,
  input  logic [fdl_pkg::DATA_W-1:0]   cell_q [MAX_DELAY],
  input  logic [AW-1:0]                addr,
  output logic [fdl_pkg::DATA_W-1:0]   val
);

  localparam int LW     = (AW + 1) / 2;
  localparam int G      = 2 ** LW;
  localparam int GSEL_W = (AW > LW) ? AW - LW : 1;
  localparam int NG     = 2 ** GSEL_W;

  logic [LW-1:0]               low;
  logic [GSEL_W-1:0]           gsel_nxt;
  logic [GSEL_W-1:0]           gsel_r;
  logic [fdl_pkg::DATA_W-1:0]  lvl1_q [NG];
  logic [fdl_pkg::DATA_W-1:0]  val_r;

  assign low      = addr[LW-1:0];
  assign gsel_nxt = GSEL_W'(addr >> LW);

  // first level: every group muxes its own leaves by the low address bits
  for (genvar g = 0; g < NG; g++) begin : g_grp
    logic [fdl_pkg::DATA_W-1:0] leaf [G];
    logic [fdl_pkg::DATA_W-1:0] hold_r;

    for (genvar e = 0; e < G; e++) begin : g_leaf
      if (g * G + e < MAX_DELAY) begin : g_real
        assign leaf[e] = cell_q[g * G + e];
      end else begin : g_pad
        assign leaf[e] = '0;
      end
    end

    always_ff @(posedge clk) begin
      if (ld.sel1) begin
        hold_r <= leaf[low];
      end
    end

    assign lvl1_q[g] = hold_r;
  end

  always_ff @(posedge clk) begin
    if (ld.sel1) begin
      gsel_r <= gsel_nxt;
    end
  end

  // second level: pick the group
  always_ff @(posedge clk) begin
    if (ld.sel2) begin
      val_r <= lvl1_q[gsel_r];
    end
  end

  assign val = val_r;

endmodule

[src/fdl_interp.sv]
// Linear interpolation datapath: weight products, sum, truncation toward zero.
module fdl_interp (
  input  logic                                clk,
  input  fdl_pkg::pipe_ld_t                   ld,
  input  logic signed [fdl_pkg::DATA_W-1:0]   a,
  input  logic signed [fdl_pkg::DATA_W-1:0]   b,
  input  logic        [fdl_pkg::FRAC_W-1:0]   frac,
  output logic signed [fdl_pkg::DATA_W-1:0]   interp_val,
  output logic signed [fdl_pkg::DATA_W-1:0]   pass_val
);

  localparam int DW = fdl_pkg::DATA_W;
  localparam int FW = fdl_pkg::FRAC_W;
  localparam int PW = fdl_pkg::PROD_W;

  logic        [FW:0]                 wa_u;
  logic signed [fdl_pkg::WGT_W-1:0]   wa;
  logic signed [fdl_pkg::WGT_W-1:0]   wb;
  logic signed [PW-1:0]               pa_nxt;
  logic signed [PW-1:0]               pb_nxt;
  logic signed [PW-1:0]               pa_r;
  logic signed [PW-1:0]               pb_r;
  logic signed [DW-1:0]               a3_r;
  logic signed [PW-1:0]               sum_nxt;
  logic signed [PW-1:0]               sum_r;
  logic signed [DW-1:0]               a4_r;
  logic signed [PW-1:0]               biased;

  // oldest entry weighs (1 - f), the next newer one weighs f
  assign wa_u   = fdl_pkg::FRAC_ONE - {1'b0, frac};
  assign wa     = $signed({1'b0, wa_u});
  assign wb     = $signed({2'b00, frac});
  assign pa_nxt = a * wa;
  assign pb_nxt = b * wb;

  always_ff @(posedge clk) begin
    if (ld.mul) begin
      pa_r <= pa_nxt;
      pb_r <= pb_nxt;
      a3_r <= a;
    end
  end

  assign sum_nxt = pa_r + pb_r;

  always_ff @(posedge clk) begin
    if (ld.add) begin
      sum_r <= sum_nxt;
      a4_r  <= a3_r;
    end
  end

  // negative sums get a bias so that dropping the fraction truncates toward zero
  assign biased     = sum_r + (sum_r[PW-1] ? PW'(fdl_pkg::FRAC_MASK) : PW'(0));
  assign interp_val = biased[DW+FW-1:FW];
  assign pass_val   = a4_r;

endmodule

[src/fdl_checker.sv]
// Port-level assertions for the fractional delay line and their bind.
module fdl_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input fdl_pkg::out_item_t   out_data
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // reset empties the result register
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // an out-of-range tap carries a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.index_error |-> out_data.sample_out == '0)
    else $error("index error with nonzero sample");

  // the input side stalls only when the result side is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked result");

endmodule

bind fractional_delay_line_core fdl_checker u_fdl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
